>>> rtl/rhp_pkg.sv
`default_nettype none

package rhp_pkg;

    localparam int PAYLOAD_MAX_DEFAULT = 2048;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int POS_W = 19;
    localparam int COUNT_W = 12;
    localparam int COUNT_MAX = 4095;

    localparam logic [POS_W-1:0] HDR_FIXED = 19'd12;
    localparam logic [POS_W-1:0] POS_MAX = 19'h7FFFF;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_VERSION = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] status_t;
    typedef logic [6:0] ptype_t;
    typedef logic [15:0] seq_t;
    typedef logic [31:0] word_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [POS_W-1:0] pos_t;

    // One queue entry: an optional payload byte and an optional summary behind it
    typedef struct packed {
        logic    pay_valid;
        byte_t   pay_byte;
        logic    sum_valid;
        status_t status;
        ptype_t  media_type;
        logic    marker;
        seq_t    sequence_res;
        word_t   time_stamp;
        word_t   source_id;
        count_t  payload_length;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/rhp_front.sv
`default_nettype none

module rhp_front #(
    parameter int PAYLOAD_MAX = rhp_pkg::PAYLOAD_MAX_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire rhp_pkg::byte_t data_byte,
    input  wire logic           last_byte,
    output rhp_pkg::entry_t     entry,
    output logic                entry_valid
);
    import rhp_pkg::*;

    localparam int PAY_CAP = (PAYLOAD_MAX > COUNT_MAX) ? COUNT_MAX : PAYLOAD_MAX;

    pos_t    pos_reg, pos_next;
    pos_t    hdr_end_reg, hdr_end_next;
    logic [3:0] csrc_reg, csrc_next;
    logic    ext_reg, ext_next;
    byte_t   ext_hi_reg, ext_hi_next;
    logic    vbad_reg, vbad_next;
    ptype_t  pt_reg, pt_next;
    logic    marker_reg, marker_next;
    seq_t    seq_reg, seq_next;
    word_t   ts_reg, ts_next;
    word_t   ssrc_reg, ssrc_next;
    count_t  cnt_reg, cnt_next;

    pos_t    base;
    pos_t    base0;
    logic    pay_hit;
    status_t st;

    always_comb
    begin
        base  = HDR_FIXED + {13'd0, csrc_reg, 2'b00};
        base0 = HDR_FIXED + {13'd0, data_byte[3:0], 2'b00};

        vbad_next    = vbad_reg;
        csrc_next    = csrc_reg;
        ext_next     = ext_reg;
        hdr_end_next = hdr_end_reg;
        ext_hi_next  = ext_hi_reg;
        pt_next      = pt_reg;
        marker_next  = marker_reg;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        ssrc_next    = ssrc_reg;

        if (pos_reg == '0)
        begin
            vbad_next    = (data_byte[7:6] != RTP_VERSION);
            csrc_next    = data_byte[3:0];
            ext_next     = data_byte[4];
            hdr_end_next = base0 + (data_byte[4] ? 19'd4 : 19'd0);
        end
        else if (pos_reg == 19'd1)
        begin
            pt_next     = data_byte[6:0];
            marker_next = data_byte[7];
        end
        else if (pos_reg < 19'd4)
        begin
            seq_next = {seq_reg[7:0], data_byte};
        end
        else if (pos_reg < 19'd8)
        begin
            ts_next = {ts_reg[23:0], data_byte};
        end
        else if (pos_reg < HDR_FIXED)
        begin
            ssrc_next = {ssrc_reg[23:0], data_byte};
        end

        // extension length word sits at base+2..base+3
        if (ext_reg && pos_reg >= HDR_FIXED)
        begin
            if (pos_reg == base + 19'd2)
                ext_hi_next = data_byte;
            else if (pos_reg == base + 19'd3)
                hdr_end_next = base + 19'd4 + {1'b0, ext_hi_reg, data_byte, 2'b00};
        end

        // header end only grows past the current byte, so the held value is safe here
        pay_hit = !vbad_reg && pos_reg >= hdr_end_reg && pos_reg >= HDR_FIXED
                  && cnt_reg < COUNT_W'(PAY_CAP);
        cnt_next = pay_hit ? cnt_reg + 1'b1 : cnt_reg;
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        if (vbad_next)
            st = ST_BAD_VERSION;
        else if (pos_next < HDR_FIXED || pos_next < hdr_end_next)
            st = ST_TRUNCATED;
        else
            st = ST_OK;

        entry.pay_valid      = pay_hit;
        entry.pay_byte       = data_byte;
        entry.sum_valid      = last_byte;
        entry.status         = st;
        entry.media_type     = (st == ST_OK) ? pt_next : '0;
        entry.marker         = (st == ST_OK) ? marker_next : 1'b0;
        entry.sequence_res   = (st == ST_OK) ? seq_next : '0;
        entry.time_stamp     = (st == ST_OK) ? ts_next : '0;
        entry.source_id      = (st == ST_OK) ? ssrc_next : '0;
        entry.payload_length = (st == ST_OK) ? cnt_next : '0;
        entry_valid          = accept && (pay_hit || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_end_reg <= HDR_FIXED;
            csrc_reg    <= '0;
            ext_reg     <= 1'b0;
            ext_hi_reg  <= '0;
            vbad_reg    <= 1'b0;
            pt_reg      <= '0;
            marker_reg  <= 1'b0;
            seq_reg     <= '0;
            ts_reg      <= '0;
            ssrc_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg     <= '0;
                hdr_end_reg <= HDR_FIXED;
                csrc_reg    <= '0;
                ext_reg     <= 1'b0;
                ext_hi_reg  <= '0;
                vbad_reg    <= 1'b0;
                pt_reg      <= '0;
                marker_reg  <= 1'b0;
                seq_reg     <= '0;
                ts_reg      <= '0;
                ssrc_reg    <= '0;
                cnt_reg     <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                hdr_end_reg <= hdr_end_next;
                csrc_reg    <= csrc_next;
                ext_reg     <= ext_next;
                ext_hi_reg  <= ext_hi_next;
                vbad_reg    <= vbad_next;
                pt_reg      <= pt_next;
                marker_reg  <= marker_next;
                seq_reg     <= seq_next;
                ts_reg      <= ts_next;
                ssrc_reg    <= ssrc_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_bad_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        vbad_reg |-> !pay_hit)
        else $error("payload passed for bad-version packet");
`endif

endmodule

`default_nettype wire

>>> rtl/rhp_fifo.sv
`default_nettype none

module rhp_fifo #(
    parameter int DEPTH = rhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire rhp_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    output rhp_pkg::entry_t      rd_data,
    output logic                 q_empty,
    output logic                 q_full
);
    import rhp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("entry written into full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/rhp_back.sv
`default_nettype none

module rhp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rhp_pkg::entry_t  q_data,
    input  wire logic             q_empty,
    output logic                  q_pop,
    input  wire logic             pop,
    output logic                  empty,
    output logic                  is_summary,
    output rhp_pkg::byte_t        payload_byte,
    output rhp_pkg::status_t      status,
    output rhp_pkg::ptype_t       media_type,
    output logic                  marker,
    output rhp_pkg::seq_t         sequence_res,
    output rhp_pkg::word_t        time_stamp,
    output rhp_pkg::word_t        source_id,
    output rhp_pkg::count_t       payload_length,
    output logic                  end_of_run
);
    import rhp_pkg::*;

    entry_t cur_reg, cur_next;
    logic   valid_reg, valid_next;
    logic   show_pay, xfer, done, load;

    assign show_pay = cur_reg.pay_valid;
    assign xfer     = pop && valid_reg;
    // a payload entry with a summary behind it takes two transfers
    assign done     = xfer && !(show_pay && cur_reg.sum_valid);
    assign load     = !valid_reg || done;
    assign q_pop    = load && !q_empty;
    assign empty    = !valid_reg;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !q_empty;
            cur_next   = q_data;
        end
        else if (xfer)
        begin
            cur_next.pay_valid = 1'b0;
        end
    end

    assign is_summary     = !show_pay;
    assign payload_byte   = show_pay ? cur_reg.pay_byte : '0;
    assign status         = show_pay ? ST_OK : cur_reg.status;
    assign media_type     = show_pay ? '0 : cur_reg.media_type;
    assign marker         = show_pay ? 1'b0 : cur_reg.marker;
    assign sequence_res   = show_pay ? '0 : cur_reg.sequence_res;
    assign time_stamp     = show_pay ? '0 : cur_reg.time_stamp;
    assign source_id      = show_pay ? '0 : cur_reg.source_id;
    assign payload_length = show_pay ? '0 : cur_reg.payload_length;
    assign end_of_run     = !show_pay;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

`ifndef NO_ASSERTIONS
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.pay_valid || cur_reg.sum_valid))
        else $error("held entry carries no result");
    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && show_pay && cur_reg.sum_valid) |=> (!empty && is_summary))
        else $error("summary lost after payload transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/rtp_header_parser.sv
`default_nettype none

// RTP fixed-header parser. Packet bytes come in one per cycle (push/full) with
// last_byte on the final byte; version, CSRC count and extension length are
// decoded on the fly and every byte past the header end of a packet with a good
// version comes out as a payload result (up to PAYLOAD_MAX, capped at 4095),
// followed on the last byte by a summary with status 0 ok, 1 bad version, 2
// truncated. Input rate is one byte per cycle while full is low; the parse
// registers update in the cycle a byte is taken. Results are written into a
// QUEUE_DEPTH-entry queue and then loaded into a one-entry output register. A
// last byte that is also payload occupies the output for two transfers, and
// full rises when the queue fills behind a stalled or slower pop side.
module rtp_header_parser #(
    parameter int PAYLOAD_MAX = rhp_pkg::PAYLOAD_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = rhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire rhp_pkg::byte_t   data_byte,
    input  wire logic             last_byte,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  is_summary,
    output rhp_pkg::byte_t        payload_byte,
    output rhp_pkg::status_t      status,
    output rhp_pkg::ptype_t       media_type,
    output logic                  marker,
    output rhp_pkg::seq_t         sequence_res,
    output rhp_pkg::word_t        time_stamp,
    output rhp_pkg::word_t        source_id,
    output rhp_pkg::count_t       payload_length,
    output logic                  end_of_run
);
    import rhp_pkg::*;

    entry_t f_entry, q_data;
    logic   f_valid, q_empty, q_full, q_pop, accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    rhp_front #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .entry      (f_entry),
        .entry_valid(f_valid)
    );

    rhp_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_valid),
        .wr_data(f_entry),
        .rd_en  (q_pop),
        .rd_data(q_data),
        .q_empty(q_empty),
        .q_full (q_full)
    );

    rhp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .is_summary    (is_summary),
        .payload_byte  (payload_byte),
        .status        (status),
        .media_type    (media_type),
        .marker        (marker),
        .sequence_res  (sequence_res),
        .time_stamp    (time_stamp),
        .source_id     (source_id),
        .payload_length(payload_length),
        .end_of_run    (end_of_run)
    );

endmodule

`default_nettype wire
